@@ rtl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types and constants of the first-fit frame allocator
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam logic [31:0] BASE_RESET = 32'h0040_0000;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ZERO      = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_CMP     = 3'd1;
   localparam logic [2:0] CMD_RELEASE = 3'd2;
   localparam logic [2:0] CMD_GRANT   = 3'd3;
   localparam logic [2:0] CMD_APPEND  = 3'd4;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] length;
      logic        busy;
   } frame_type;

   typedef struct packed {
      logic [2:0]  code;
      logic [31:0] size;
      logic [31:0] address;
      logic        split;
      frame_type   split_frame;
      logic [31:0] append_start;
   } cmd_type;

endpackage

@@ rtl/ffa_cell.sv @@
// ----------------------------------------------------------------------------
// ffa_cell
// one table slot: holds a frame, compares it and takes its neighbor's frame
// ----------------------------------------------------------------------------
module ffa_cell import ffa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  frame_type prev_frame,
   input  logic      prev_sel,
   input  logic      sel,
   input  logic      after,
   input  logic      app,
   output frame_type frame,
   output logic      fit,
   output logic      match
);

   frame_type frame_ff, frame_in;
   logic      fit_ff, fit_in;
   logic      match_ff, match_in;
   logic      valid;

   assign valid = (frame_ff.start != 32'd0);

   always_comb begin
      frame_in = frame_ff;
      fit_in   = fit_ff;
      match_in = match_ff;
      unique case (cmd.code)
         CMD_CMP: begin
            fit_in   = valid && !frame_ff.busy && (frame_ff.length >= cmd.size);
            match_in = valid && (frame_ff.start == cmd.address);
         end
         CMD_RELEASE: begin
            if (match_ff) frame_in.busy = 1'b0;
         end
         CMD_GRANT: begin
            if (sel) begin
               frame_in.busy = 1'b1;
               if (cmd.split) frame_in.length = cmd.size;
            end else if (after && cmd.split) begin
               frame_in = prev_sel ? cmd.split_frame : prev_frame;
            end
         end
         CMD_APPEND: begin
            if (app) begin
               frame_in.start  = cmd.append_start;
               frame_in.length = cmd.size;
               frame_in.busy   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         fit_ff   <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         frame_ff <= frame_in;
         fit_ff   <= fit_in;
         match_ff <= match_in;
      end
   end

   assign frame = frame_ff;
   assign fit   = fit_ff;
   assign match = match_ff;

endmodule

@@ rtl/first_fit_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_frame_allocator
// first-fit allocator over an address-ordered table of frames
// ----------------------------------------------------------------------------
// Each request word passes through four steps: accept, compare in every cell,
// select the first fitting cell, then commit the update along the row of cells.
// The result lands in the output register at the commit edge, and the next word
// can be taken in the cycle after that.
// Splitting a frame moves every later frame one cell along the row in the
// commit cycle. A new request is taken while a result still waits; the commit
// cycle holds until the output register is free.
module first_fit_frame_allocator import ffa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // request_size, release_address
   input  logic        req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // granted_address, status, zero fill
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_SEL  = 2'd2;
   localparam logic [1:0] S_ACT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] base_ff;
   logic        op_ff;
   logic [31:0] size_ff, addr_ff;

   frame_type          frames [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] fit_v, match_v, valid_v;

   logic [TABLE_ENTRIES-1:0] sel_ff, sel_in, after_ff, after_in, app_ff, app_in;
   logic        any_fit_ff, any_match_ff, full_ff, empty_ff;
   logic [31:0] sel_start_ff, sel_start_in, sel_len_ff, sel_len_in;
   logic [32:0] tail_end_ff, tail_end_in;

   logic        rsp_valid_ff;
   logic [31:0] rsp_addr_ff, res_addr;
   logic [2:0]  rsp_status_ff, res_status;
   logic        fire;
   cmd_type     cmd;
   logic [32:0] place;
   logic [33:0] place_end;

   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      frame_type pf;
      logic      ps;
      if (k == 0) begin : g_first
         assign pf = '0;
         assign ps = 1'b0;
      end else begin : g_rest
         assign pf = frames[k-1];
         assign ps = sel_ff[k-1];
      end
      assign valid_v[k] = (frames[k].start != 32'd0);
      ffa_cell u_cell (
         .clock(clock), .reset(reset), .cmd(cmd),
         .prev_frame(pf), .prev_sel(ps),
         .sel(sel_ff[k]), .after(after_ff[k]), .app(app_ff[k]),
         .frame(frames[k]), .fit(fit_v[k]), .match(match_v[k])
      );
   end

   // selection from the compare results
   always_comb begin
      sel_in       = fit_v & (~fit_v + 1'b1);
      after_in     = ~(sel_in - 1'b1) & ~sel_in;
      sel_start_in = '0;
      sel_len_in   = '0;
      tail_end_in  = '0;
      app_in       = '0;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         if (sel_in[k]) begin
            sel_start_in = sel_start_in | frames[k].start;
            sel_len_in   = sel_len_in | frames[k].length;
         end
         if (valid_v[k] && (k == TABLE_ENTRIES - 1 || !valid_v[(k + 1) % TABLE_ENTRIES]))
            tail_end_in = tail_end_in | ({1'b0, frames[k].start} + {1'b0, frames[k].length});
         if (!valid_v[k] && (k == 0 || valid_v[(k + TABLE_ENTRIES - 1) % TABLE_ENTRIES]))
            app_in[k] = 1'b1;
      end
   end

   assign fire  = (state_ff == S_ACT) && (!rsp_valid_ff || rsp_tready);
   assign place = empty_ff ? {1'b0, base_ff} : tail_end_ff;
   assign place_end = {1'b0, place} + {2'b00, size_ff};

   always_comb begin
      cmd              = '0;
      cmd.size         = size_ff;
      cmd.address      = addr_ff;
      cmd.split        = (sel_len_ff > size_ff) && !full_ff;
      cmd.split_frame  = '{start: sel_start_ff + size_ff,
                            length: sel_len_ff - size_ff, busy: 1'b0};
      cmd.append_start = place[31:0];
      res_addr         = '0;
      res_status       = ST_OK;
      if (state_ff == S_CMP) cmd.code = CMD_CMP;
      if (op_ff == OP_RELEASE) begin
         if (addr_ff != 32'd0) begin
            if (any_match_ff) cmd.code = fire ? CMD_RELEASE : CMD_NONE;
            else res_status = ST_NOT_FOUND;
         end
      end else if (size_ff == 32'd0) begin
         res_status = ST_ZERO;
      end else if (any_fit_ff) begin
         res_addr = sel_start_ff;
         if (fire) cmd.code = CMD_GRANT;
      end else if (full_ff) begin
         res_status = ST_FULL;
      end else if (place == 33'd0 || place_end > 34'h1_0000_0000) begin
         res_status = ST_OVERFLOW;
      end else begin
         res_addr = place[31:0];
         if (fire) cmd.code = CMD_APPEND;
      end
      if (state_ff == S_CMP) cmd.code = CMD_CMP;
      else if (!fire) cmd.code = CMD_NONE;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_CMP;
         S_CMP:  state_in = S_SEL;
         S_SEL:  state_in = S_ACT;
         S_ACT:  if (fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) base_ff <= csr_write_data;
         if (fire) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         op_ff   <= req_tuser;
         size_ff <= req_tdata[31:0];
         addr_ff <= req_tdata[63:32];
      end
      if (state_ff == S_SEL) begin
         sel_ff       <= sel_in;
         after_ff     <= after_in;
         app_ff       <= app_in;
         any_fit_ff   <= |fit_v;
         any_match_ff <= |match_v;
         full_ff      <= valid_v[TABLE_ENTRIES-1];
         empty_ff     <= !valid_v[0];
         sel_start_ff <= sel_start_in;
         sel_len_ff   <= sel_len_in;
         tail_end_ff  <= tail_end_in;
      end
      if (fire) begin
         rsp_addr_ff   <= res_addr;
         rsp_status_ff <= res_status;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_status_ff, rsp_addr_ff};

endmodule

@@ rtl/ffa_checker.sv @@
// ----------------------------------------------------------------------------
// ffa_checker
// port-level checks of the first-fit frame allocator
// ----------------------------------------------------------------------------
module ffa_checker import ffa_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:32] <= ST_OVERFLOW)
      else $error("status out of range");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34:32] != ST_OK |-> rsp_tdata[31:0] == 32'd0)
      else $error("address given with a failure");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("word taken while one is in work");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word after reset");

endmodule

bind first_fit_frame_allocator ffa_checker u_ffa_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// random and directed requests against a first-fit frame table, every result
// word checked against a table kept alongside the block
// ----------------------------------------------------------------------------
module tb_top;
   import ffa_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   first_fit_frame_allocator u_top (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic        op;
      logic [31:0] size;
      logic [31:0] where;
   } request_word;

   typedef struct packed {
      logic [31:0] address;
      logic [2:0]  status;
   } grant_word;

   request_word pending_requests[$];
   grant_word   expected_grants[$];
   int          error_count = 0;
   int          hold_off = 0;

   // shadow table
   logic [31:0] shadow_start[TABLE_ENTRIES];
   logic [31:0] shadow_length[TABLE_ENTRIES];
   logic        shadow_busy[TABLE_ENTRIES];
   logic [31:0] shadow_base;
   logic [31:0] granted_list[$];

   function automatic int frames_in_use();
      int n;
      n = 0;
      while (n < TABLE_ENTRIES && shadow_start[n] != 0) n++;
      return n;
   endfunction

   function automatic grant_word allocate_frame(logic [31:0] size);
      grant_word g;
      int cnt;
      logic [32:0] s;
      g.address = '0;
      if (size == 0) begin
         g.status = ST_ZERO;
         return g;
      end
      cnt = frames_in_use();
      for (int j = 0; j < cnt; j++) begin
         if (!shadow_busy[j] && shadow_length[j] >= size) begin
            if (shadow_length[j] > size && cnt < TABLE_ENTRIES) begin
               for (int k = cnt; k > j + 1; k--) begin
                  shadow_start[k] = shadow_start[k-1];
                  shadow_length[k] = shadow_length[k-1];
                  shadow_busy[k] = shadow_busy[k-1];
               end
               shadow_start[j+1] = shadow_start[j] + size;
               shadow_length[j+1] = shadow_length[j] - size;
               shadow_busy[j+1] = 1'b0;
               shadow_length[j] = size;
            end
            shadow_busy[j] = 1'b1;
            g.address = shadow_start[j];
            g.status = ST_OK;
            return g;
         end
      end
      if (cnt >= TABLE_ENTRIES) begin
         g.status = ST_FULL;
         return g;
      end
      if (cnt == 0) s = {1'b0, shadow_base};
      else s = {1'b0, shadow_start[cnt-1]} + {1'b0, shadow_length[cnt-1]};
      if (s == 0 || {1'b0, s} + {2'b0, size} > 34'h1_0000_0000) begin
         g.status = ST_OVERFLOW;
         return g;
      end
      shadow_start[cnt] = s[31:0];
      shadow_length[cnt] = size;
      shadow_busy[cnt] = 1'b1;
      g.address = s[31:0];
      g.status = ST_OK;
      return g;
   endfunction

   function automatic grant_word predict_grant(request_word r);
      grant_word g;
      int cnt;
      if (r.op == OP_ALLOC) return allocate_frame(r.size);
      g.address = '0;
      g.status = ST_OK;
      if (r.where == 0) return g;
      cnt = frames_in_use();
      for (int i = 0; i < cnt; i++) begin
         if (shadow_start[i] == r.where) begin
            shadow_busy[i] = 1'b0;
            return g;
         end
      end
      g.status = ST_NOT_FOUND;
      return g;
   endfunction

   logic req_tready_seen = 1'b0;
   logic rsp_word_seen = 1'b0;

   // driver
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready_seen) begin
            req_tvalid <= 1'b0;
            send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
         end else if (!req_tvalid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() > 0) begin
               request_word r;
               r = pending_requests.pop_front();
               req_tuser <= r.op;
               req_tdata <= {r.where, r.size};
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // acceptance seen at the rising edge
   always @(posedge clock) begin
      req_tready_seen <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         request_word r;
         r.op = req_tuser;
         r.size = req_tdata[31:0];
         r.where = req_tdata[63:32];
         expected_grants.push_back(predict_grant(r));
      end
   end

   // monitor
   int recv_gap = 0;
   always @(posedge clock) begin
      rsp_word_seen <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         grant_word e;
         if (expected_grants.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            e = expected_grants.pop_front();
            if (rsp_tdata[31:0] !== e.address) begin
               $error("granted_address expected %h actual %h", e.address, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[34:32] !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_tdata[34:32]);
               error_count++;
            end
            if (e.status == ST_OK && e.address != 0) granted_list.push_back(e.address);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_tready <= 1'b0;
      end else if (rsp_word_seen) begin
         recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
         rsp_tready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= (recv_gap == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic queue_request(logic op, logic [31:0] size, logic [31:0] where);
      request_word r;
      r.op = op;
      r.size = size;
      r.where = where;
      pending_requests.push_back(r);
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || req_tvalid || expected_grants.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_base(logic [31:0] value);
      @(negedge clock);
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_base = value;
   endtask

   function automatic logic [31:0] random_size();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return $urandom;
         2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom_range(1, 4096);
      endcase
   endfunction

   function automatic logic [31:0] random_where();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return $urandom;
         default: return granted_list.size() > 0 ?
            granted_list[$urandom_range(0, granted_list.size() - 1)] : $urandom;
      endcase
   endfunction

   initial begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         shadow_start[i] = '0;
         shadow_length[i] = '0;
         shadow_busy[i] = 1'b0;
      end
      shadow_base = BASE_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero request, fits, splits, releases, overflow
      queue_request(OP_ALLOC, 32'd0, 32'd0);
      queue_request(OP_ALLOC, 32'd100, 32'd0);
      queue_request(OP_ALLOC, 32'd50, 32'd0);
      queue_request(OP_RELEASE, 32'hFFFF_FFFF, BASE_RESET);
      queue_request(OP_ALLOC, 32'd100, 32'd0);
      queue_request(OP_RELEASE, 32'd0, BASE_RESET);
      queue_request(OP_ALLOC, 32'd40, 32'd0);
      queue_request(OP_RELEASE, 32'd0, BASE_RESET);
      queue_request(OP_RELEASE, 32'd0, BASE_RESET);
      queue_request(OP_RELEASE, 32'd0, 32'd0);
      queue_request(OP_RELEASE, 32'd0, 32'hFFFF_FFFF);
      queue_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
      queue_request(OP_ALLOC, 32'd1, 32'hFFFF_FFFF);
      drain();

      // pressure: receiver holds off while sender keeps offering
      hold_off = 400;
      for (int i = 0; i < 70; i++) queue_request(OP_ALLOC, 32'd16, 32'd0);
      drain();

      write_base(32'hFFFF_FFF0);
      repeat (2) @(posedge clock);
      for (int i = 0; i < 80; i++) queue_request(OP_RELEASE, 32'd0, BASE_RESET + 16 * i);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            shadow_start[i] = shadow_start[i];
         end
         case (phase)
            0: write_base(32'd1);
            1: write_base(32'hFFFF_FFFF);
            2: write_base($urandom);
            default: write_base(BASE_RESET);
         endcase
         for (int i = 0; i < 197; i++) begin
            if ($urandom_range(0, 1)) queue_request(OP_ALLOC, random_size(), $urandom);
            else queue_request(OP_RELEASE, $urandom, random_where());
            if (pending_requests.size() > 8) @(posedge clock);
            while (pending_requests.size() > 8) @(posedge clock);
         end
         drain();
      end

      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top: errors");
      $finish;
   end
endmodule

@@ files.f @@
rtl/ffa_pkg.sv
rtl/ffa_cell.sv
rtl/first_fit_frame_allocator.sv
rtl/ffa_checker.sv
tb/tb_top.sv
